@@ src/tpi_pkg.sv @@
package tpi_pkg;

  localparam int unsigned STAMP_W = 63;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned GAP_W   = 32;
  localparam logic [GAP_W-1:0] GAP_RESET = 32'd100000000;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [STAMP_W-1:0]        stamp;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [HEAD_W-1:0]  heading;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [POS_W-1:0]   res_x;
    logic signed [POS_W-1:0]   res_y;
    logic signed [HEAD_W-1:0]  res_heading;
  } rsp_t;

  // One stored sample
  typedef struct packed {
    logic [STAMP_W-1:0]        stamp;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [HEAD_W-1:0]  heading;
  } sample_t;

  // Commands from the controller to every cell
  typedef struct packed {
    logic   insert;    // insert new sample in this cycle
    logic   scan;      // shift the table by one toward the head (rotate)
    logic   clear;
    sample_t smp;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

endpackage

@@ src/tpi_cell.sv @@
// One table entry: holds a sample and a valid flag. On insert, a cell takes
// the new sample if it is the first cell whose stamp is greater, or the
// first empty cell; cells past that point take their left neighbor.
// On scan the contents rotate one place toward the head.
module tpi_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  tpi_pkg::cell_cmd_t   cmd,
  input  tpi_pkg::sample_t     left_smp,
  input  logic                 left_valid,
  input  logic                 left_after,
  input  tpi_pkg::sample_t     right_smp,
  input  logic                 right_valid,
  output tpi_pkg::sample_t     smp,
  output logic                 valid,
  output logic                 after
);

  logic here_after;

  // This cell lies at or after the insert point
  assign here_after = !valid || (smp.stamp > cmd.smp.stamp);
  assign after      = here_after;

  // valid flags are control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      if (here_after) begin
        valid <= left_after ? left_valid : 1'b1;
      end
    end else if (cmd.scan) begin
      valid <= right_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (here_after) begin
        smp <= left_after ? left_smp : cmd.smp;
      end
    end else if (cmd.scan) begin
      smp <= right_smp;
    end
  end

endmodule

@@ src/tpi_chain.sv @@
// Row of cells. The head cell's sample is visible to the controller;
// rotating the row presents every entry at the head in turn.
module tpi_chain #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tpi_pkg::cell_cmd_t   cmd,
  output tpi_pkg::sample_t     head_smp,
  output logic                 head_valid,
  output logic                 full
);

  tpi_pkg::sample_t smp   [DEPTH];
  logic             valid [DEPTH];
  logic             after [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tpi_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_smp    ((g == 0) ? cmd.smp : smp[(g == 0) ? 0 : g - 1]),
      .left_valid  ((g == 0) ? 1'b0 : valid[(g == 0) ? 0 : g - 1]),
      .left_after  ((g == 0) ? 1'b0 : after[(g == 0) ? 0 : g - 1]),
      .right_smp   (smp[(g + 1) % DEPTH]),
      .right_valid (valid[(g + 1) % DEPTH]),
      .smp         (smp[g]),
      .valid       (valid[g]),
      .after       (after[g])
    );
  end

  assign head_smp   = smp[0];
  assign head_valid = valid[0];
  // valid cells always form a prefix between operations
  assign full       = valid[DEPTH-1];

endmodule

@@ src/tpi_lerp.sv @@
// Serial alpha divider followed by a shared multiplier that forms
// lo + trunc(delta * alpha / 2^ALPHA_BITS) for x, y and yaw in turn.
module tpi_lerp #(
  parameter int unsigned ALPHA_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpi_pkg::STAMP_W-1:0]   num,
  input  logic [tpi_pkg::STAMP_W-1:0]   span,
  input  tpi_pkg::sample_t              lo,
  input  tpi_pkg::sample_t              hi,
  output logic                          done,
  output logic signed [tpi_pkg::POS_W-1:0]  out_x,
  output logic signed [tpi_pkg::POS_W-1:0]  out_y,
  output logic signed [tpi_pkg::HEAD_W-1:0] out_heading
);

  localparam int unsigned SW  = tpi_pkg::STAMP_W;
  localparam int unsigned CW  = $clog2(ALPHA_BITS + 1);
  localparam int unsigned DW  = tpi_pkg::POS_W + 1;
  localparam int unsigned PW  = DW + ALPHA_BITS;

  logic [SW:0]           rem;
  logic [SW:0]           rem_sh;
  logic [ALPHA_BITS-1:0] alpha;
  logic [CW-1:0]         cnt;
  logic                  dividing;
  logic [1:0]            lane;
  logic                  multiplying;

  logic signed [DW-1:0]  d_x, d_y, d_h, d_sel, lo_sel;
  logic [DW-1:0]         mag;
  logic [PW-1:0]         prod;
  logic [DW-1:0]         part;
  logic signed [DW-1:0]  res;

  assign rem_sh = {rem[SW-1:0], 1'b0};

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dividing    <= 1'b0;
      multiplying <= 1'b0;
      done        <= 1'b0;
      cnt         <= '0;
      lane        <= '0;
    end else begin
      done <= multiplying && (lane == 2'd2);
      if (start) begin
        dividing <= 1'b1;
        cnt      <= '0;
      end else if (dividing) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ALPHA_BITS - 1)) begin
          dividing    <= 1'b0;
          multiplying <= 1'b1;
          lane        <= '0;
        end
      end else if (multiplying) begin
        lane <= lane + 1'b1;
        if (lane == 2'd2) begin
          multiplying <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      alpha <= '0;
    end else if (dividing) begin
      if (rem_sh >= {1'b0, span}) begin
        rem <= rem_sh - {1'b0, span};
        alpha <= {alpha[ALPHA_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        alpha <= {alpha[ALPHA_BITS-2:0], 1'b0};
      end
    end
  end

  // deltas
  assign d_x = DW'(hi.x) - DW'(lo.x);
  assign d_y = DW'(hi.y) - DW'(lo.y);
  assign d_h = DW'(signed'(tpi_pkg::HEAD_W'(hi.heading - lo.heading)));

  always_comb begin
    unique case (lane)
      2'd0:    begin d_sel = d_x; lo_sel = DW'(lo.x); end
      2'd1:    begin d_sel = d_y; lo_sel = DW'(lo.y); end
      default: begin d_sel = d_h; lo_sel = DW'(lo.heading); end
    endcase
    mag  = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
    prod = PW'(mag) * PW'(alpha);
    part = prod[PW-1:ALPHA_BITS];
    res  = d_sel[DW-1] ? lo_sel - signed'(part) : lo_sel + signed'(part);
  end

  always_ff @(posedge clk) begin
    if (multiplying) begin
      unique case (lane)
        2'd0:    out_x <= res[tpi_pkg::POS_W-1:0];
        2'd1:    out_y <= res[tpi_pkg::POS_W-1:0];
        default: out_heading <= res[tpi_pkg::HEAD_W-1:0];
      endcase
    end
  end

endmodule

@@ src/timestamped_pose_interpolator_core.sv @@
// Operation: add and clear write the row and load the response register as they are
//   taken; lookup rotates the cell row once, evaluates, then runs the divider to interpolate.
// Throughput: one request at a time; the next is taken when the response
//   register has been emptied or is being taken.
// Reset: rst synchronous active high; empties the table, restores
//   max_time_gap to 100000000 ns.
module timestamped_pose_interpolator_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ALPHA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tpi_pkg::req_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tpi_pkg::rsp_t               out_data,
  input  logic                        cfg_we,
  input  logic [tpi_pkg::GAP_W-1:0]   cfg_data
);

  localparam int unsigned SW = tpi_pkg::STAMP_W;
  localparam int unsigned IW = $clog2(DEPTH + 1);

  tpi_pkg::state_t    state, state_next;
  tpi_pkg::req_t      req;
  tpi_pkg::cell_cmd_t cmd;
  tpi_pkg::sample_t   head_smp;
  logic               head_valid;
  logic               full;
  logic [tpi_pkg::GAP_W-1:0] max_time_gap;

  // scan bookkeeping
  logic [IW-1:0]      step;
  logic               have_lo;     // a sample with stamp < t seen
  logic               have_hi;     // first sample with stamp >= t seen
  logic               any;
  tpi_pkg::sample_t   lo_smp, hi_smp;

  logic               accept;
  logic               take_out;
  logic               div_start, div_done;
  logic signed [tpi_pkg::POS_W-1:0]  l_x, l_y;
  logic signed [tpi_pkg::HEAD_W-1:0] l_h;

  logic [SW-1:0] dlo, dhi, span;
  logic          far_lo, far_hi;

  tpi_pkg::rsp_t rsp_next;
  logic          rsp_load;

  assign take_out = out_valid && !out_stall;
  assign in_stall = (state != tpi_pkg::S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_time_gap <= tpi_pkg::GAP_RESET;
    end else if (cfg_we) begin
      max_time_gap <= cfg_data;
    end
  end

  // cell row
  always_comb begin
    cmd.smp.stamp   = accept ? in_data.stamp : req.stamp;
    cmd.smp.x       = in_data.pos_x;
    cmd.smp.y       = in_data.pos_y;
    cmd.smp.heading = in_data.heading;
    cmd.insert = accept && (in_data.op == tpi_pkg::OP_ADD) && !full;
    cmd.clear  = accept && (in_data.op == tpi_pkg::OP_CLEAR);
    cmd.scan   = (state == tpi_pkg::S_SCAN);
  end

  tpi_chain #(.DEPTH(DEPTH)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .head_smp   (head_smp),
    .head_valid (head_valid),
    .full       (full)
  );

  // neighbor distances
  assign dlo    = req.stamp - lo_smp.stamp;
  assign dhi    = hi_smp.stamp - req.stamp;
  assign span   = hi_smp.stamp - lo_smp.stamp;
  assign far_lo = dlo > SW'(max_time_gap);
  assign far_hi = dhi > SW'(max_time_gap);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpi_pkg::S_IDLE:
        if (accept && in_data.op == tpi_pkg::OP_LOOKUP) state_next = tpi_pkg::S_SCAN;
      tpi_pkg::S_SCAN:
        if (step == IW'(DEPTH - 1)) state_next = tpi_pkg::S_EVAL;
      tpi_pkg::S_EVAL:
        if (any && have_lo && have_hi && !(far_lo && far_hi) && span != '0
            && dlo < span) state_next = tpi_pkg::S_DIV;
        else state_next = tpi_pkg::S_IDLE;
      tpi_pkg::S_DIV:
        if (div_done) state_next = tpi_pkg::S_IDLE;
      default: state_next = tpi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tpi_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign div_start = (state == tpi_pkg::S_EVAL) && (state_next == tpi_pkg::S_DIV);

  // scan: sample the head cell each cycle as the row rotates
  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= in_data;
      step    <= '0;
      have_lo <= 1'b0;
      have_hi <= 1'b0;
      any     <= 1'b0;
    end else if (state == tpi_pkg::S_SCAN) begin
      step <= step + 1'b1;
      if (head_valid) begin
        any <= 1'b1;
        if (head_smp.stamp < req.stamp) begin
          lo_smp  <= head_smp;
          have_lo <= 1'b1;
        end else if (!have_hi) begin
          hi_smp  <= head_smp;
          have_hi <= 1'b1;
        end
      end
    end
  end

  tpi_lerp #(.ALPHA_BITS(ALPHA_BITS)) u_lerp (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .num         (dlo),
    .span        (span),
    .lo          (lo_smp),
    .hi          (hi_smp),
    .done        (div_done),
    .out_x       (l_x),
    .out_y       (l_y),
    .out_heading (l_h)
  );

  // response contents
  always_comb begin
    rsp_next = '0;
    rsp_load = 1'b0;
    if (accept && in_data.op != tpi_pkg::OP_LOOKUP) begin
      rsp_load = 1'b1;
      if (in_data.op == tpi_pkg::OP_ADD && full) begin
        rsp_next.status = tpi_pkg::ST_FULL;
      end else if (in_data.op == tpi_pkg::OP_NONE) begin
        rsp_next.status = tpi_pkg::ST_NONE;
      end
    end else if (state == tpi_pkg::S_EVAL) begin
      rsp_load = 1'b1;
      priority if (!any) begin
        rsp_next.status = tpi_pkg::ST_NONE;
      end else if (!have_lo) begin
        if (far_hi) rsp_next.status = tpi_pkg::ST_NONE;
        else begin
          rsp_next.res_x = hi_smp.x; rsp_next.res_y = hi_smp.y;
          rsp_next.res_heading = hi_smp.heading;
        end
      end else if (!have_hi) begin
        if (far_lo) rsp_next.status = tpi_pkg::ST_NONE;
        else begin
          rsp_next.res_x = lo_smp.x; rsp_next.res_y = lo_smp.y;
          rsp_next.res_heading = lo_smp.heading;
        end
      end else if (far_lo && far_hi) begin
        rsp_next.status = tpi_pkg::ST_NONE;
      end else if (span == '0) begin
        rsp_next.res_x = lo_smp.x; rsp_next.res_y = lo_smp.y;
        rsp_next.res_heading = lo_smp.heading;
      end else if (dlo >= span) begin
        rsp_next.res_x = hi_smp.x; rsp_next.res_y = hi_smp.y;
        rsp_next.res_heading = hi_smp.heading;
      end else begin
        // interpolation follows in the divider
        rsp_load = 1'b0;
      end
    end else if (state == tpi_pkg::S_DIV && div_done) begin
      rsp_load             = 1'b1;
      rsp_next.status      = tpi_pkg::ST_OK;
      rsp_next.res_x       = l_x;
      rsp_next.res_y       = l_y;
      rsp_next.res_heading = l_h;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_load) begin
      out_valid <= 1'b1;
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_data <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  // no request is taken while busy
  assert property (@(posedge clk) disable iff (rst)
    state != tpi_pkg::S_IDLE |-> !accept) else $error("accept while busy");
  // a response that is not OK carries a zero res_x and res_heading
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != tpi_pkg::ST_OK |->
    out_data.res_x == '0 && out_data.res_heading == '0) else $error("pose not zero");
  // divider finishes only while waiting on it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == tpi_pkg::S_DIV) else $error("stray divider done");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  tpi_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  tpi_pkg::rsp_t out_data;
  logic cfg_we;
  logic [tpi_pkg::GAP_W-1:0] cfg_data;

  timestamped_pose_interpolator_core #(
    .DEPTH(TABLE_DEPTH),
    .ALPHA_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // Clock, 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predicted table and tolerance
  logic [tpi_pkg::STAMP_W-1:0] pose_stamp[TABLE_DEPTH];
  logic signed [tpi_pkg::POS_W-1:0] pose_x[TABLE_DEPTH];
  logic signed [tpi_pkg::POS_W-1:0] pose_y[TABLE_DEPTH];
  logic signed [tpi_pkg::HEAD_W-1:0] pose_head[TABLE_DEPTH];
  int pose_count;
  logic [tpi_pkg::GAP_W-1:0] time_tolerance;

  tpi_pkg::req_t request_queue[$];
  tpi_pkg::rsp_t expected_poses[$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int send_hold;
  int requests_sent;
  int responses_seen;
  int lookups_ok;
  int lookups_missed;
  int adds_dropped;
  int quiet_cycles;
  logic in_taken;

  // d * a / 2^FRAC_BITS truncated toward zero, added to base
  function automatic logic signed [63:0] blend(logic signed [63:0] base,
                                               logic signed [63:0] d,
                                               logic [63:0] a);
    logic [63:0] mag;
    logic [127:0] prod;
    logic signed [63:0] part;
    mag = d < 0 ? -d : d;
    prod = mag * a;
    part = prod[FRAC_BITS+63:FRAC_BITS];
    return d < 0 ? base - part : base + part;
  endfunction

  // Apply one request to the predicted table, return the expected response
  function automatic tpi_pkg::rsp_t predict_pose(tpi_pkg::req_t r);
    tpi_pkg::rsp_t p;
    int pos;
    int k;
    logic [63:0] t;
    logic [63:0] dlo;
    logic [63:0] dhi;
    logic [63:0] span;
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0] alpha;
    logic signed [tpi_pkg::HEAD_W-1:0] dh;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vh;
    p = '0;
    t = {1'b0, r.stamp};
    case (tpi_pkg::op_t'(r.op))
      tpi_pkg::OP_ADD: begin
        if (pose_count >= TABLE_DEPTH) begin
          p.status = tpi_pkg::ST_FULL;
          adds_dropped++;
        end else begin
          pos = pose_count;
          while (pos > 0 && pose_stamp[pos-1] > r.stamp) pos--;
          for (k = pose_count; k > pos; k--) begin
            pose_stamp[k] = pose_stamp[k-1];
            pose_x[k] = pose_x[k-1];
            pose_y[k] = pose_y[k-1];
            pose_head[k] = pose_head[k-1];
          end
          pose_stamp[pos] = r.stamp;
          pose_x[pos] = r.pos_x;
          pose_y[pos] = r.pos_y;
          pose_head[pos] = r.heading;
          pose_count++;
        end
      end
      tpi_pkg::OP_CLEAR: pose_count = 0;
      tpi_pkg::OP_NONE: p.status = tpi_pkg::ST_NONE;
      default: begin
        if (pose_count == 0) begin
          p.status = tpi_pkg::ST_NONE;
        end else begin
          k = 0;
          while (k < pose_count && pose_stamp[k] < r.stamp) k++;
          if (k == 0 || k == pose_count) begin
            pos = (k == 0) ? 0 : k - 1;
            dlo = (k == 0) ? {1'b0, pose_stamp[0]} - t : t - {1'b0, pose_stamp[pos]};
            if (dlo > 64'(time_tolerance)) begin
              p.status = tpi_pkg::ST_NONE;
            end else begin
              p.res_x = pose_x[pos];
              p.res_y = pose_y[pos];
              p.res_heading = pose_head[pos];
            end
          end else begin
            dhi = {1'b0, pose_stamp[k]} - t;
            dlo = t - {1'b0, pose_stamp[k-1]};
            span = {1'b0, pose_stamp[k]} - {1'b0, pose_stamp[k-1]};
            if (dhi > 64'(time_tolerance) && dlo > 64'(time_tolerance)) begin
              p.status = tpi_pkg::ST_NONE;
            end else if (span == 0) begin
              p.res_x = pose_x[k-1];
              p.res_y = pose_y[k-1];
              p.res_heading = pose_head[k-1];
            end else if (dlo >= span) begin
              p.res_x = pose_x[k];
              p.res_y = pose_y[k];
              p.res_heading = pose_head[k];
            end else begin
              num = {64'd0, dlo} << FRAC_BITS;
              quo = num / {64'd0, span};
              alpha = quo[63:0];
              dh = pose_head[k] - pose_head[k-1];
              vx = blend(64'(pose_x[k-1]), 64'(pose_x[k]) - 64'(pose_x[k-1]), alpha);
              vy = blend(64'(pose_y[k-1]), 64'(pose_y[k]) - 64'(pose_y[k-1]), alpha);
              vh = blend(64'(pose_head[k-1]), 64'(dh), alpha);
              p.res_x = vx[tpi_pkg::POS_W-1:0];
              p.res_y = vy[tpi_pkg::POS_W-1:0];
              p.res_heading = vh[tpi_pkg::HEAD_W-1:0];
            end
          end
          if (p.status == tpi_pkg::ST_OK) lookups_ok++;
          else lookups_missed++;
        end
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h (response %0d)",
             what, got, want, responses_seen);
    error_count++;
  endtask

  function automatic tpi_pkg::req_t make_req(tpi_pkg::op_t op,
                                             logic [tpi_pkg::STAMP_W-1:0] stamp,
                                             logic [31:0] x, logic [31:0] y,
                                             logic [31:0] h);
    tpi_pkg::req_t r;
    r.op = op;
    r.stamp = stamp;
    r.pos_x = x;
    r.pos_y = y;
    r.heading = h[15:0];
    return r;
  endfunction

  // Append one request to the pending list
  task automatic queue_req(tpi_pkg::req_t r);
    request_queue.insert(request_queue.size(), r);
  endtask

  function automatic logic [tpi_pkg::STAMP_W-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[tpi_pkg::STAMP_W-1:0];
  endfunction

  // Driver: pops pending requests once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_hold == 0 && request_queue.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= request_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_taken || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("** timestamped_pose_interpolator_core: FAILED **");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected response", 64'(out_data.status), 64'd0);
        end else begin
          tpi_pkg::rsp_t e;
          e = expected_poses.pop_front();
          if (out_data.status !== e.status)
            report_mismatch("status", 64'(out_data.status), 64'(e.status));
          if (out_data.res_x !== e.res_x)
            report_mismatch("res_x", 64'(out_data.res_x), 64'(e.res_x));
          if (out_data.res_y !== e.res_y)
            report_mismatch("res_y", 64'(out_data.res_y), 64'(e.res_y));
          if (out_data.res_heading !== e.res_heading)
            report_mismatch("res_heading", 64'(out_data.res_heading), 64'(e.res_heading));
        end
        responses_seen++;
      end
      if (in_taken) begin
        expected_poses.insert(expected_poses.size(), predict_pose(in_data));
        requests_sent++;
      end
    end
  end

  task automatic drain();
    while (request_queue.size() > 0 || in_valid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [tpi_pkg::GAP_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    time_tolerance = v;
  endtask

  // Random traffic: mostly adds and lookups near a moving time base
  task automatic random_phase(int n);
    logic [tpi_pkg::STAMP_W-1:0] base;
    logic [tpi_pkg::STAMP_W-1:0] st;
    int sel;
    int i;
    base = rand_stamp();
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      case ($urandom_range(9))
        0: st = rand_stamp();
        1: st = base;
        default: st = base + tpi_pkg::STAMP_W'($urandom_range(200000000));
      endcase
      if (sel < 45) begin
        queue_req(make_req(tpi_pkg::OP_ADD, st, $urandom, $urandom, $urandom));
      end else if (sel < 93) begin
        queue_req(make_req(tpi_pkg::OP_LOOKUP, st, $urandom, $urandom, $urandom));
      end else if (sel < 97) begin
        queue_req(make_req(tpi_pkg::OP_CLEAR, st, $urandom, $urandom, $urandom));
        base = rand_stamp();
      end else begin
        queue_req(make_req(tpi_pkg::OP_NONE, st, $urandom, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    in_taken = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    error_count = 0;
    pose_count = 0;
    time_tolerance = tpi_pkg::GAP_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_hold = 0;
    requests_sent = 0;
    responses_seen = 0;
    lookups_ok = 0;
    lookups_missed = 0;
    adds_dropped = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lookup, ends, equal stamps, half-turn yaw, wrap, undefined op
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'd1000, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_NONE, 63'd5, 32'h7fffffff, 32'h80000000, 32'h7fff));
    queue_req(make_req(tpi_pkg::OP_ADD, 63'd1000, 32'h7fffffff, 32'h80000000, 32'h0000));
    queue_req(make_req(tpi_pkg::OP_ADD, 63'd3000, 32'h80000000, 32'h7fffffff, 32'h8000));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'd1700, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'd3000, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'd0, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_ADD, 63'd3000, 32'h1234, 32'h5678, 32'h7000));
    queue_req(make_req(tpi_pkg::OP_ADD, 63'd5000, 32'hffff0000, 32'h10000, 32'h9000));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'd4001, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'h7fffffffffffffff, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_ADD, 63'h7fffffffffffffff, 32'hffffffff, 0, 32'hffff));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'h7ffffffffffffff0, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_CLEAR, 63'd0, 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_LOOKUP, 63'd3000, 0, 0, 0));
    drain();

    // Full table: fill past depth with random stamps, then look up
    write_tolerance('0);
    for (i = 0; i < TABLE_DEPTH + 3; i++)
      queue_req(make_req(tpi_pkg::OP_ADD, rand_stamp(), $urandom, $urandom, $urandom));
    for (i = 0; i < 20; i++)
      queue_req(make_req(tpi_pkg::OP_LOOKUP, rand_stamp(), 0, 0, 0));
    drain();
    write_tolerance('1);
    for (i = 0; i < 20; i++)
      queue_req(make_req(tpi_pkg::OP_LOOKUP, rand_stamp(), 0, 0, 0));
    queue_req(make_req(tpi_pkg::OP_CLEAR, 63'd0, 0, 0, 0));
    drain();

    // Random phases with different stall mixes and tolerances
    write_tolerance(tpi_pkg::GAP_RESET);
    send_idle_pct = 16;
    recv_idle_pct = 88;
    random_phase(380);
    drain();

    write_tolerance(32'd50000000);
    send_idle_pct = 88;
    recv_idle_pct = 16;
    random_phase(200);
    // hold the sender until everything has drained
    wait (request_queue.size() == 0);
    send_hold = 1;
    wait (!in_valid && expected_poses.size() == 0);
    send_hold = 0;
    random_phase(180);
    drain();

    write_tolerance($urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(380);
    drain();

    $display("sent %0d requests, checked %0d responses", requests_sent, responses_seen);
    $display("lookups hit %0d, missed %0d; adds dropped on full table %0d",
             lookups_ok, lookups_missed, adds_dropped);
    if (error_count == 0 && expected_poses.size() == 0) begin
      $display("** timestamped_pose_interpolator_core: PASSED **");
    end else begin
      $display("** timestamped_pose_interpolator_core: FAILED **");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/tpi_pkg.sv
src/tpi_cell.sv
src/tpi_chain.sv
src/tpi_lerp.sv
src/timestamped_pose_interpolator_core.sv
tb/sv/tb_top.sv
